// ===== rtl/scfe_pkg.sv =====
// Shared types and constants for the simple CPU fetch-execute block.
package scfe_pkg;

    localparam int REG_COUNT = 16;
    localparam int RIDX_W    = $clog2(REG_COUNT);

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_STEP  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_SETPC = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_EXEC   = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_HALTED = 2'd2,
        ST_ACCESS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        WK_NONE = 2'd0,
        WK_REG  = 2'd1,
        WK_MEM  = 2'd2
    } t_wkind;

    localparam logic [3:0] OP_LOAD_MEM = 4'h1;
    localparam logic [3:0] OP_LOAD_IMM = 4'h2;
    localparam logic [3:0] OP_STORE    = 4'h3;
    localparam logic [3:0] OP_MOVE     = 4'h4;
    localparam logic [3:0] OP_ADD      = 4'h5;
    localparam logic [3:0] OP_JUMP     = 4'hB;
    localparam logic [3:0] OP_HALT     = 4'hC;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] address;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  prog_counter;
        logic [15:0] instr_word;
        logic        is_halted;
        t_status     status;
        logic [7:0]  read_data;
        t_wkind      write_kind;
        logic [7:0]  write_index;
        logic [7:0]  write_value;
    } t_out_item;

    // Register file access for one cycle: two reads, one write.
    typedef struct packed {
        logic              re;
        logic [RIDX_W-1:0] ra;
        logic [RIDX_W-1:0] rb;
        logic              we;
        logic [RIDX_W-1:0] wa;
        logic [7:0]        wd;
    } t_rf_req;

endpackage

// ===== rtl/scfe_if.sv =====
// Valid/ready channel interfaces for the input and result transactions.
interface scfe_in_if import scfe_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface scfe_out_if import scfe_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/scfe_mem.sv =====
// Single-port main memory, registered read, per-entry valid bits for reset.
module scfe_mem #(
    parameter int MEM_DEPTH = 256,
    parameter int AW        = $clog2(MEM_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0]           r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_valid;
    logic [7:0]           r_rdata;
    logic                 r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en && i_we) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
                r_rd_ok <= r_valid[i_addr];
            end
        end
    end

    // never-written entries read as zero
    assign o_rdata = r_rd_ok ? r_rdata : 8'd0;

endmodule

// ===== rtl/scfe_regs.sv =====
// Byte register file: two registered read ports, one write port.
module scfe_regs import scfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_rf_req    i_req,
    output logic [7:0] o_rd_a,
    output logic [7:0] o_rd_b
);

    logic [7:0]           r_rf [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    logic [7:0]           r_rd_a;
    logic [7:0]           r_rd_b;
    logic                 r_ok_a;
    logic                 r_ok_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_rf[i_req.wa] <= i_req.wd;
        end
        if (i_req.re) begin
            r_rd_a <= r_rf[i_req.ra];
            r_rd_b <= r_rf[i_req.rb];
            r_ok_a <= r_valid[i_req.ra];
            r_ok_b <= r_valid[i_req.rb];
        end
    end

    assign o_rd_a = r_ok_a ? r_rd_a : 8'd0;
    assign o_rd_b = r_ok_b ? r_rd_b : 8'd0;

endmodule

// ===== rtl/simple_cpu_fetch_execute_top.sv =====
// Simple 8-bit CPU: sequencer around a single-port main memory and a register file.
// Finishing state (one memory byte per cycle): write, pc set, halted step: S_IDLE;
//   read: S_READ; empty word, imm. load, halt, unused opcode: S_FETCH2; others: S_OPER.
// Result shows the cycle after the finishing state; input reopens then unless the output
//   register is still full, in which case the result parks and input waits for it.
// Synchronous active-low reset clears pc, instruction register, halt flag, valid bits.
module simple_cpu_fetch_execute_top import scfe_pkg::*; #(
    parameter int MEM_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scfe_in_if.sink     i_in,
    scfe_out_if.source  o_out
);

    localparam int AW = $clog2(MEM_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FETCH1 = 6'b000010,
        S_FETCH2 = 6'b000100,
        S_OPER   = 6'b001000,
        S_READ   = 6'b010000,
        S_HOLD   = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [7:0] r_pc, n_pc;
    logic [15:0] r_ir, n_ir;
    logic       r_halt, n_halt;
    logic [7:0] r_b1, n_b1;
    logic [7:0] r_b2, n_b2;
    t_out_item  r_res, n_res;
    t_out_item  r_out;
    logic       r_out_valid;

    // memory and register file access for this cycle
    logic          mem_en;
    logic          mem_we;
    logic [7:0]    mem_addr8;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;
    t_rf_req       rf_req;
    logic [7:0]    rf_a;
    logic [7:0]    rf_b;

    // finishing transaction
    logic      fin;
    t_out_item res;
    logic      out_free;
    logic      out_load;
    t_out_item out_item;
    logic      in_acc;

    // Addresses wrap modulo the memory depth; the table is built at elaboration.
    logic [AW-1:0] c_wrap [256];
    for (genvar g = 0; g < 256; g++) begin : g_wrap
        assign c_wrap[g] = AW'(g % MEM_DEPTH);
    end
    assign mem_addr = c_wrap[mem_addr8];

    scfe_mem #(
        .MEM_DEPTH (MEM_DEPTH),
        .AW        (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    scfe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rf_req),
        .o_rd_a  (rf_a),
        .o_rd_b  (rf_b)
    );

    assign i_in.ready    = (r_state == S_IDLE);
    assign in_acc        = i_in.valid && i_in.ready;
    assign out_free      = !r_out_valid || o_out.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_ir      = r_ir;
        n_halt    = r_halt;
        n_b1      = r_b1;
        n_b2      = r_b2;
        n_res     = r_res;
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr8 = r_pc;
        mem_wdata = 8'd0;
        rf_req    = '0;
        fin       = 1'b0;
        res       = '0;
        res.status     = ST_ACCESS;
        res.write_kind = WK_NONE;
        out_load  = 1'b0;
        out_item  = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in.payload.mode)
                        MODE_WRITE: begin
                            mem_en          = 1'b1;
                            mem_we          = 1'b1;
                            mem_addr8       = i_in.payload.address;
                            mem_wdata       = i_in.payload.data;
                            fin             = 1'b1;
                            res.write_kind  = WK_MEM;
                            res.write_index = 8'(c_wrap[i_in.payload.address]);
                            res.write_value = i_in.payload.data;
                        end
                        MODE_READ: begin
                            mem_en    = 1'b1;
                            mem_addr8 = i_in.payload.address;
                            n_state   = S_READ;
                        end
                        MODE_SETPC: begin
                            n_pc = i_in.payload.address;
                            fin  = 1'b1;
                        end
                        MODE_STEP: begin
                            if (r_halt) begin
                                n_ir       = 16'd0;
                                fin        = 1'b1;
                                res.status = ST_HALTED;
                            end else begin
                                mem_en    = 1'b1;
                                mem_addr8 = r_pc;
                                n_state   = S_FETCH1;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                fin           = 1'b1;
                res.read_data = mem_rdata;
            end
            S_FETCH1: begin
                n_b1      = mem_rdata;
                mem_en    = 1'b1;
                mem_addr8 = r_pc + 8'd1;
                n_state   = S_FETCH2;
            end
            S_FETCH2: begin
                n_b2 = mem_rdata;
                if (r_b1 == 8'd0) begin
                    fin        = 1'b1;
                    res.status = ST_EMPTY;
                end else begin
                    n_ir       = {r_b1, mem_rdata};
                    n_pc       = r_pc + 8'd2;
                    res.status = ST_EXEC;
                    // operands are read here, the result is written in S_OPER
                    unique case (r_b1[7:4])
                        OP_LOAD_MEM: begin
                            mem_en    = 1'b1;
                            mem_addr8 = mem_rdata;
                            n_state   = S_OPER;
                        end
                        OP_LOAD_IMM: begin
                            rf_req.we       = 1'b1;
                            rf_req.wa       = r_b1[3:0];
                            rf_req.wd       = mem_rdata;
                            fin             = 1'b1;
                            res.write_kind  = WK_REG;
                            res.write_index = 8'(r_b1[3:0]);
                            res.write_value = mem_rdata;
                        end
                        OP_STORE: begin
                            rf_req.re = 1'b1;
                            rf_req.ra = r_b1[3:0];
                            n_state   = S_OPER;
                        end
                        OP_MOVE: begin
                            rf_req.re = 1'b1;
                            rf_req.ra = mem_rdata[7:4];
                            n_state   = S_OPER;
                        end
                        OP_ADD: begin
                            rf_req.re = 1'b1;
                            rf_req.ra = mem_rdata[7:4];
                            rf_req.rb = mem_rdata[3:0];
                            n_state   = S_OPER;
                        end
                        OP_JUMP: begin
                            rf_req.re = 1'b1;
                            rf_req.ra = r_b1[3:0];
                            rf_req.rb = '0;
                            n_state   = S_OPER;
                        end
                        OP_HALT: begin
                            n_halt = 1'b1;
                            fin    = 1'b1;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_OPER: begin
                fin        = 1'b1;
                res.status = ST_EXEC;
                unique case (r_b1[7:4])
                    OP_LOAD_MEM: begin
                        rf_req.we       = 1'b1;
                        rf_req.wa       = r_b1[3:0];
                        rf_req.wd       = mem_rdata;
                        res.write_kind  = WK_REG;
                        res.write_index = 8'(r_b1[3:0]);
                        res.write_value = mem_rdata;
                    end
                    OP_STORE: begin
                        mem_en          = 1'b1;
                        mem_we          = 1'b1;
                        mem_addr8       = r_b2;
                        mem_wdata       = rf_a;
                        res.write_kind  = WK_MEM;
                        res.write_index = 8'(c_wrap[r_b2]);
                        res.write_value = rf_a;
                    end
                    OP_MOVE: begin
                        rf_req.we       = 1'b1;
                        rf_req.wa       = r_b2[3:0];
                        rf_req.wd       = rf_a;
                        res.write_kind  = WK_REG;
                        res.write_index = 8'(r_b2[3:0]);
                        res.write_value = rf_a;
                    end
                    OP_ADD: begin
                        rf_req.we       = 1'b1;
                        rf_req.wa       = r_b1[3:0];
                        rf_req.wd       = rf_a + rf_b;
                        res.write_kind  = WK_REG;
                        res.write_index = 8'(r_b1[3:0]);
                        res.write_value = rf_a + rf_b;
                    end
                    OP_JUMP: begin
                        if (rf_a == rf_b) begin
                            n_pc = r_b2;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_HOLD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_item = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        res.prog_counter = n_pc;
        res.instr_word   = n_ir;
        res.is_halted    = n_halt;

        // finished: straight into the output register, or park until it frees up
        if (fin) begin
            if (out_free) begin
                out_load = 1'b1;
                out_item = res;
                n_state  = S_IDLE;
            end else begin
                n_res   = res;
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= 8'd0;
            r_ir        <= 16'd0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_ir    <= n_ir;
            r_halt  <= n_halt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1  <= n_b1;
        r_b2  <= n_b2;
        r_res <= n_res;
        if (out_load) begin
            r_out <= out_item;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the simple CPU block: directed table, random programs, self-checking predictor.
module tb_top;
    import scfe_pkg::*;

    localparam int MEM_DEPTH   = 256;
    localparam int BOOT_ROWS   = 24;
    localparam int HALT_ROWS   = 8;
    localparam int RAND_ITEMS  = 1400;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 350;      // transactions accepted before the long hold-off
    localparam logic [7:0] DATA_BASE = 8'hD0;  // stores land at or above this address

    // One stimulus row. Rows with 'typed' set carry a hand-written result.
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_stim;

    logic clk;
    logic rst_n;

    scfe_in_if  in_ch ();
    scfe_out_if out_ch ();

    simple_cpu_fetch_execute_top #(.MEM_DEPTH(MEM_DEPTH)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // ------------------------------------------------------------------
    // Clock: 8 ns period
    // ------------------------------------------------------------------
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Machine state mirror, updated once per accepted transaction
    // ------------------------------------------------------------------
    logic [7:0]  cpu_regs [16];
    logic [7:0]  cpu_mem  [MEM_DEPTH];
    logic [7:0]  cpu_pc;
    logic [15:0] cpu_ir;
    logic        cpu_halted;

    t_stim     stim_q[$];      // transactions still to be offered
    t_out_item expect_q[$];    // results owed by the block, oldest first

    int fail_count   = 0;
    int n_accepted   = 0;
    int n_exec       = 0;
    int n_empty      = 0;
    int n_halt_steps = 0;
    int n_access     = 0;

    // Every memory address wraps at the memory depth.
    function automatic logic [7:0] mem_addr(int a);
        return 8'((a & 255) % MEM_DEPTH);
    endfunction

    // Apply one transaction to the mirror and return the result it must produce.
    function automatic t_out_item cpu_step(t_in_item it);
        t_out_item  r;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] a;
        logic [3:0] rn;
        logic [3:0] rx;
        logic [3:0] ry;
        r = '0;
        r.status = ST_ACCESS;
        r.write_kind = WK_NONE;
        case (it.mode)
            MODE_WRITE: begin
                a = mem_addr(int'(it.address));
                cpu_mem[a] = it.data;
                r.write_kind  = WK_MEM;
                r.write_index = a;
                r.write_value = it.data;
            end
            MODE_READ: r.read_data = cpu_mem[mem_addr(int'(it.address))];
            MODE_SETPC: cpu_pc = it.address;
            MODE_STEP: begin
                if (cpu_halted) begin
                    // halted wins over everything, even an empty word
                    cpu_ir   = '0;
                    r.status = ST_HALTED;
                end else begin
                    b1 = cpu_mem[mem_addr(int'(cpu_pc))];
                    b2 = cpu_mem[mem_addr(int'(cpu_pc) + 1)];
                    if (b1 == 8'h00) begin
                        r.status = ST_EMPTY;
                    end else begin
                        rn = b1[3:0];
                        rx = b2[7:4];
                        ry = b2[3:0];
                        cpu_ir   = {b1, b2};
                        cpu_pc   = cpu_pc + 8'd2;
                        r.status = ST_EXEC;
                        case (b1[7:4])
                            OP_LOAD_MEM: begin
                                cpu_regs[rn]  = cpu_mem[mem_addr(int'(b2))];
                                r.write_kind  = WK_REG;
                                r.write_index = 8'(rn);
                                r.write_value = cpu_regs[rn];
                            end
                            OP_LOAD_IMM: begin
                                cpu_regs[rn]  = b2;
                                r.write_kind  = WK_REG;
                                r.write_index = 8'(rn);
                                r.write_value = b2;
                            end
                            OP_STORE: begin
                                a = mem_addr(int'(b2));
                                cpu_mem[a]    = cpu_regs[rn];
                                r.write_kind  = WK_MEM;
                                r.write_index = a;
                                r.write_value = cpu_regs[rn];
                            end
                            OP_MOVE: begin
                                cpu_regs[ry]  = cpu_regs[rx];
                                r.write_kind  = WK_REG;
                                r.write_index = 8'(ry);
                                r.write_value = cpu_regs[ry];
                            end
                            OP_ADD: begin
                                cpu_regs[rn]  = cpu_regs[rx] + cpu_regs[ry];
                                r.write_kind  = WK_REG;
                                r.write_index = 8'(rn);
                                r.write_value = cpu_regs[rn];
                            end
                            // target overrides the already advanced counter
                            OP_JUMP: if (cpu_regs[rn] == cpu_regs[0]) cpu_pc = b2;
                            OP_HALT: cpu_halted = 1'b1;
                            default: ;   // unused opcode: fetch and advance only
                        endcase
                    end
                end
            end
            default: ;
        endcase
        r.prog_counter = cpu_pc;
        r.instr_word   = cpu_ir;
        r.is_halted    = cpu_halted;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    function automatic t_stim row(t_mode m, logic [7:0] a, logic [7:0] d);
        t_stim s;
        s.item  = '{mode: m, address: a, data: d};
        s.typed = 1'b0;
        s.want  = '0;
        return s;
    endfunction

    function automatic t_stim row_want(t_mode m, logic [7:0] a, logic [7:0] d,
                                       logic [7:0] pc, logic [15:0] ir, logic hlt,
                                       t_status st, logic [7:0] rd, t_wkind wk,
                                       logic [7:0] wi, logic [7:0] wv);
        t_stim s;
        s       = row(m, a, d);
        s.typed = 1'b1;
        s.want  = '{pc, ir, hlt, st, rd, wk, wi, wv};
        return s;
    endfunction

    function automatic void push_item(t_mode m, logic [7:0] a, logic [7:0] d);
        stim_q.push_back(row(m, a, d));
    endfunction

    // Halt is saved for the end of the run: reset is never repeated, so a
    // stray halt would leave every later step idle. Turn C_ into D_.
    function automatic logic [7:0] no_halt_byte(logic [7:0] v);
        return (v[7:4] == OP_HALT) ? (v | 8'h10) : v;
    endfunction

    // One random instruction word for a program at 'base' of 'n_words' words.
    function automatic logic [15:0] rand_instr(logic [7:0] base, int n_words);
        int         pick;
        logic [3:0] rn;
        logic [7:0] b2;
        rn   = 4'($urandom_range(0, 15));
        b2   = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            // load from the data area half the time, anywhere otherwise
            if ($urandom_range(0, 1) == 0) b2 = 8'($urandom_range(int'(DATA_BASE), 255));
            return {OP_LOAD_MEM, rn, b2};
        end
        if (pick < 30) return {OP_LOAD_IMM, rn, b2};
        if (pick < 42)
            return {OP_STORE, rn, 8'($urandom_range(int'(DATA_BASE), 255))};
        if (pick < 56) return {OP_MOVE, rn, b2};
        if (pick < 74) return {OP_ADD, rn, b2};
        if (pick < 86) begin
            // comparing against R0 itself always takes the jump
            if ($urandom_range(0, 3) == 0) rn = 4'h0;
            return {OP_JUMP, rn, base + 8'(2 * $urandom_range(0, n_words - 1))};
        end
        if (pick < 90) return {8'h00, b2};    // empty word: stalls until the next pc set
        // unused opcodes: 0 with a nonzero register field, 6..A, D..F
        case ($urandom_range(0, 2))
            0:       return {4'h0, 4'($urandom_range(1, 15)), b2};
            1:       return {4'($urandom_range(6, 10)), rn, b2};
            default: return {4'($urandom_range(13, 15)), rn, b2};
        endcase
    endfunction

    // Load a short program at an even base, point pc at it and run it.
    // Run-off past the end is bounded so that pc stays below the data area.
    task automatic add_program();
        int          n_words;
        int          n_steps;
        logic [7:0]  base;
        logic [15:0] w;
        n_words = $urandom_range(2, 12);
        base    = 8'(2 * $urandom_range(0, (192 - 4 * n_words) / 2));
        for (int k = 0; k < n_words; k++) begin
            w = rand_instr(base, n_words);
            push_item(MODE_WRITE, base + 8'(2 * k), w[15:8]);
            push_item(MODE_WRITE, base + 8'(2 * k + 1), w[7:0]);
        end
        push_item(MODE_SETPC, base, 8'($urandom));
        n_steps = $urandom_range(n_words, 2 * n_words);
        repeat (n_steps) push_item(MODE_STEP, 8'($urandom), 8'($urandom));
    endtask

    // Random memory writes, reads and pc sets between programs.
    task automatic add_noise();
        int         n;
        logic [7:0] a;
        logic [7:0] d;
        n = $urandom_range(1, 8);
        repeat (n) begin
            a = 8'($urandom);
            d = 8'($urandom);
            case ($urandom_range(0, 2))
                0:       push_item(MODE_WRITE, a, (a < DATA_BASE) ? no_halt_byte(d) : d);
                1:       push_item(MODE_READ, a, d);
                default: push_item(MODE_SETPC, a, d);
            endcase
        end
    endtask

    t_stim boot_tbl [BOOT_ROWS];
    t_stim halt_tbl [HALT_ROWS];

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps in between.
    // Prediction happens here, at the edge where the transaction is taken.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk) begin : sender
        t_stim     cur;
        t_out_item pred;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                cur  = stim_q.pop_front();
                pred = cpu_step(cur.item);
                expect_q.push_back(cur.typed ? cur.want : pred);
                n_accepted++;
                if (cur.item.mode != MODE_STEP) n_access++;
                else if (pred.status == ST_EXEC) n_exec++;
                else if (pred.status == ST_EMPTY) n_empty++;
                else n_halt_steps++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 48);
                    // a third of the bursts run straight into the next one
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            // an offer not yet taken stays as it is
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (stim_q.size() > 0) begin
                    in_ch.valid   <= 1'b1;
                    in_ch.payload <= stim_q[0].item;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready pattern cycles through four styles in turn,
    // plus one long hold-off driven from its own process.
    // ------------------------------------------------------------------
    bit rx_hold;
    int rx_cycle = 0;

    always @(posedge clk) begin : receiver
        int phase;
        phase = (rx_cycle / 600) % 4;
        rx_cycle++;
        if (!rst_n || rx_hold) begin
            out_ch.ready <= 1'b0;
        end else begin
            case (phase)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       out_ch.ready <= ($urandom_range(0, 9) < 3);
                default: out_ch.ready <= ((rx_cycle % 5) < 2);
            endcase
        end
    end

    // Long stall on the result side while the sender keeps offering, so the
    // block backs up and drops its input ready.
    initial begin : holdoff
        rx_hold = 1'b0;
        while (n_accepted < HOLD_AFTER) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expect_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result: expected none, actual %h",
                         $time, out_ch.payload);
            end else begin
                want = expect_q.pop_front();
                check_field("prog_counter", 16'(want.prog_counter),
                            16'(out_ch.payload.prog_counter));
                check_field("instr_word", want.instr_word, out_ch.payload.instr_word);
                check_field("is_halted", 16'(want.is_halted), 16'(out_ch.payload.is_halted));
                check_field("status", 16'(want.status), 16'(out_ch.payload.status));
                check_field("read_data", 16'(want.read_data), 16'(out_ch.payload.read_data));
                check_field("write_kind", 16'(want.write_kind),
                            16'(out_ch.payload.write_kind));
                check_field("write_index", 16'(want.write_index),
                            16'(out_ch.payload.write_index));
                check_field("write_value", 16'(want.write_value),
                            16'(out_ch.payload.write_value));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main
        rst_n          = 1'b0;
        foreach (cpu_regs[i]) cpu_regs[i] = '0;
        foreach (cpu_mem[i]) cpu_mem[i] = '0;
        cpu_pc     = '0;
        cpu_ir     = '0;
        cpu_halted = 1'b0;

        // Boot table: reset contents, extremes, pc wrap at 0xFF, an unused
        // opcode, then a small program at an odd pc covering load, immediate,
        // add with carry-out dropped, store, move and a taken jump.
        boot_tbl = '{
            row_want(MODE_READ,  8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, ST_ACCESS, 8'h00,
                     WK_NONE, 8'h00, 8'h00),
            // empty word right after reset; address and data are ignored
            row_want(MODE_STEP,  8'hFF, 8'hFF, 8'h00, 16'h0000, 1'b0, ST_EMPTY, 8'h00,
                     WK_NONE, 8'h00, 8'h00),
            row_want(MODE_WRITE, 8'hFF, 8'hFF, 8'h00, 16'h0000, 1'b0, ST_ACCESS, 8'h00,
                     WK_MEM, 8'hFF, 8'hFF),
            row_want(MODE_WRITE, 8'h00, 8'h1E, 8'h00, 16'h0000, 1'b0, ST_ACCESS, 8'h00,
                     WK_MEM, 8'h00, 8'h1E),
            row_want(MODE_SETPC, 8'hFF, 8'h00, 8'hFF, 16'h0000, 1'b0, ST_ACCESS, 8'h00,
                     WK_NONE, 8'h00, 8'h00),
            // fetch FF:1E across the top of memory, opcode F does nothing, pc -> 01
            row_want(MODE_STEP,  8'h00, 8'h00, 8'h01, 16'hFF1E, 1'b0, ST_EXEC, 8'h00,
                     WK_NONE, 8'h00, 8'h00),
            row(MODE_WRITE, 8'h01, 8'h2F), row(MODE_WRITE, 8'h02, 8'h80),   // R15 <- 80
            row(MODE_STEP,  8'h00, 8'h00),
            row(MODE_WRITE, 8'h03, 8'h1E), row(MODE_WRITE, 8'h04, 8'h02),   // R14 <- [02]
            row(MODE_STEP,  8'h00, 8'h00),
            row(MODE_WRITE, 8'h05, 8'h5D), row(MODE_WRITE, 8'h06, 8'hEF),   // R13 <- 80+80
            row(MODE_STEP,  8'h00, 8'h00),
            row(MODE_WRITE, 8'h07, 8'h3F), row(MODE_WRITE, 8'h08, 8'hFE),   // [FE] <- R15
            row(MODE_STEP,  8'h00, 8'h00),
            row(MODE_WRITE, 8'h09, 8'h4F), row(MODE_WRITE, 8'h0A, 8'hE1),   // R1 <- R14
            row(MODE_STEP,  8'h00, 8'h00),
            row(MODE_WRITE, 8'h0B, 8'hBD), row(MODE_WRITE, 8'h0C, 8'h01),   // R13==R0: pc 01
            row(MODE_STEP,  8'h00, 8'h00)
        };

        // Halt table, run last: halt, a halted step over an empty word, then
        // memory write, read and pc set still working while halted.
        halt_tbl = '{
            row(MODE_WRITE, 8'hF0, 8'hC5),
            row(MODE_WRITE, 8'hF2, 8'h00),
            row(MODE_SETPC, 8'hF0, 8'h00),
            row(MODE_STEP,  8'h00, 8'h00),
            row_want(MODE_STEP,  8'h00, 8'h00, 8'hF2, 16'h0000, 1'b1, ST_HALTED, 8'h00,
                     WK_NONE, 8'h00, 8'h00),
            row_want(MODE_WRITE, 8'hF2, 8'h7E, 8'hF2, 16'h0000, 1'b1, ST_ACCESS, 8'h00,
                     WK_MEM, 8'hF2, 8'h7E),
            row_want(MODE_READ,  8'hF2, 8'h00, 8'hF2, 16'h0000, 1'b1, ST_ACCESS, 8'h7E,
                     WK_NONE, 8'h00, 8'h00),
            row_want(MODE_SETPC, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, ST_ACCESS, 8'h00,
                     WK_NONE, 8'h00, 8'h00)
        };

        foreach (boot_tbl[i]) stim_q.push_back(boot_tbl[i]);
        // mostly well-formed programs, one segment in five is noise
        while (stim_q.size() < BOOT_ROWS + RAND_ITEMS) begin
            if ($urandom_range(0, 4) == 0) add_noise();
            else add_program();
        end
        foreach (halt_tbl[i]) stim_q.push_back(halt_tbl[i]);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // everything offered and taken, then everything owed returned
        while (stim_q.size() != 0 || in_ch.valid) @(posedge clk);
        while (expect_q.size() != 0) @(posedge clk);
        // room for a stray extra result to show up
        repeat (12) @(posedge clk);

        $display("Run summary: %0d transactions, %0d memory/pc accesses, %0d executed steps,",
                 n_accepted, n_access, n_exec);
        $display("             %0d empty-word steps, %0d steps while halted, %0d errors",
                 n_empty, n_halt_steps, fail_count);
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("Timeout: simulation did not drain");
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== simple_cpu_fetch_execute_top.f =====
rtl/scfe_pkg.sv
rtl/scfe_if.sv
rtl/scfe_mem.sv
rtl/scfe_regs.sv
rtl/simple_cpu_fetch_execute_top.sv
dv/tb_top.sv
